/* rtl/smsum_pkg.sv */
// Shared types, constants and modular arithmetic helpers for the subarray minimum sum unit.
package smsum_pkg;

  // Fixed field widths of the request and result channels.
  localparam int IN_VALUE_W = 16;
  localparam int RES_W      = 30;

  // Defaults for the top-level parameters.
  localparam int MAX_LEN_DEF    = 1024;
  localparam int VALUE_BITS_DEF = 16;

  // Widest value times count product: 16-bit value by 17-bit count.
  localparam int PROD_W = 33;
  localparam int QE_W   = PROD_W - RES_W;

  localparam logic [RES_W-1:0] MOD_P = 30'd1000000007;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  last;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] total;
    logic             overflow;
  } out_t;

  // Reduce a product below 2^33 modulo P. The top bits give a quotient estimate
  // that is never too large and leaves a remainder below 2P, so one correction
  // step finishes the job.
  function automatic logic [RES_W-1:0] mod_reduce(input logic [PROD_W-1:0] x);
    logic [QE_W-1:0]   qe;
    logic [PROD_W-1:0] r1;
    logic [PROD_W-1:0] p_ext;
    p_ext = {{QE_W{1'b0}}, MOD_P};
    qe    = x[PROD_W-1:RES_W];
    r1    = x - ({{RES_W{1'b0}}, qe} * p_ext);
    if (r1 >= p_ext) begin
      return RES_W'(r1 - p_ext);
    end
    return RES_W'(r1);
  endfunction

  // Sum of two residues, modulo P.
  function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_P}) begin
      return RES_W'(s - {1'b0, MOD_P});
    end
    return RES_W'(s);
  endfunction

  // Difference of two residues, modulo P.
  function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, MOD_P} - {1'b0, b};
    if (a >= b) begin
      return a - b;
    end
    return RES_W'(s);
  endfunction

endpackage

/* rtl/subarray_minimum_sum_unit.sv */
// Top level: sum of the minimums of all contiguous subarrays, modulo 1000000007.
// An element steps through compare, reduce, add and accumulate, with one more
// compare and reduce for each stack entry it pops; the pop loop reads the next
// stack entry during reduce. Pops amortize to at most one per element.
// An element past MAX_LEN only sets the overflow flag and, if last, ends the run.
// The result register loads in S_OUT once free and frees the request side at once.
// Synchronous active-low reset clears the stack depth, sums, counters and flags.
module subarray_minimum_sum_unit
  import smsum_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Derived widths.
  localparam int VW    = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int AW    = $clog2(MAX_LEN);
  localparam int DW    = $clog2(MAX_LEN + 1);
  localparam int EW    = $clog2(MAX_LEN + 2);
  localparam int ENT_W = VW + CW;

  // State codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Control registers.
  logic [2:0]       state_r, state_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [RES_W-1:0] es_r, es_nxt;
  logic [RES_W-1:0] rt_r, rt_nxt;
  logic [EW-1:0]    elem_cnt_r, elem_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             sub_pend_r, sub_pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [VW-1:0]     v_r, v_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic              pop_r, pop_nxt;
  logic [VW-1:0]     top_val_r, top_val_nxt;
  logic [CW-1:0]     top_cnt_r, top_cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [RES_W-1:0]  red_r, red_nxt;
  out_t              out_data_r, out_data_nxt;

  // Memory port signals.
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic [DW-1:0]    depth_m2;

  logic             pop_now;
  logic             out_free;
  logic [VW-1:0]    mul_val;
  logic [CW-1:0]    mul_cnt;

  // The read always targets the entry below the top; a push writes the slot above the top,
  // so the two ports never touch the same entry in one pop step.
  assign depth_m2 = depth_r - DW'(2);
  assign rd_addr  = depth_m2[AW-1:0];
  assign wr_addr  = depth_r[AW-1:0];
  assign wr_data  = {v_r, cnt_r};

  assign pop_now  = (depth_r != '0) && (top_val_r >= v_r);
  assign out_free = !out_valid_r || !out_stall;

  assign mul_val  = pop_now ? top_val_r : v_r;
  assign mul_cnt  = pop_now ? top_cnt_r : cnt_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smsum_stack_ram #(
    .ADDR_W(AW),
    .DATA_W(ENT_W)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequencer: compare to cached top, pop or push, reduce, add, accumulate, emit.
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    es_nxt        = es_r;
    rt_nxt        = rt_r;
    elem_cnt_nxt  = elem_cnt_r;
    ovf_nxt       = ovf_r;
    sub_pend_nxt  = sub_pend_r;
    out_valid_nxt = out_valid_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    pop_nxt       = pop_r;
    top_val_nxt   = top_val_r;
    top_cnt_nxt   = top_cnt_r;
    prod_nxt      = prod_r;
    red_nxt       = red_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;

    // The result register empties when the far side takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last;
          if (elem_cnt_r < EW'(MAX_LEN)) begin
            elem_cnt_nxt = elem_cnt_r + EW'(1);
            v_nxt        = in_data.value[VW-1:0];
            cnt_nxt      = CW'(1);
            state_nxt    = S_CMP;
          end else begin
            elem_cnt_nxt = EW'(MAX_LEN + 1);
            ovf_nxt      = 1'b1;
            if (in_data.last) begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_CMP: begin
        // Retire the subtraction left by the previous pop.
        if (sub_pend_r) begin
          es_nxt = mod_sub(es_r, red_r);
        end
        sub_pend_nxt = 1'b0;
        prod_nxt     = {{(PROD_W - VW){1'b0}}, mul_val} * {{(PROD_W - CW){1'b0}}, mul_cnt};
        pop_nxt      = pop_now;
        if (pop_now) begin
          cnt_nxt   = CW'(cnt_r + top_cnt_r);
          depth_nxt = depth_r - DW'(1);
        end else begin
          wr_en       = 1'b1;
          top_val_nxt = v_r;
          top_cnt_nxt = cnt_r;
          depth_nxt   = depth_r + DW'(1);
        end
        state_nxt = S_RED;
      end
      S_RED: begin
        red_nxt = mod_reduce(prod_r);
        if (pop_r) begin
          // The entry below the old top is now the cached top.
          top_val_nxt  = rd_data[ENT_W-1:CW];
          top_cnt_nxt  = rd_data[CW-1:0];
          sub_pend_nxt = 1'b1;
          state_nxt    = S_CMP;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        es_nxt    = mod_add(es_r, red_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rt_nxt    = mod_add(rt_r, es_r);
        state_nxt = last_r ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          out_data_nxt.total    = ovf_r ? '0 : rt_r;
          out_data_nxt.overflow = ovf_r;
          out_valid_nxt         = 1'b1;
          depth_nxt             = '0;
          es_nxt                = '0;
          rt_nxt                = '0;
          elem_cnt_nxt          = '0;
          ovf_nxt               = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      es_r        <= '0;
      rt_r        <= '0;
      elem_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      sub_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      es_r        <= es_nxt;
      rt_r        <= rt_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      ovf_r       <= ovf_nxt;
      sub_pend_r  <= sub_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    pop_r      <= pop_nxt;
    top_val_r  <= top_val_nxt;
    top_cnt_r  <= top_cnt_nxt;
    prod_r     <= prod_nxt;
    red_r      <= red_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/smsum_stack_ram.sv */
// Stack memory: one write port and one read port with registered read data.
module smsum_stack_ram
  import smsum_pkg::*;
#(
  parameter int ADDR_W = $clog2(MAX_LEN_DEF),
  parameter int DATA_W = VALUE_BITS_DEF + $clog2(MAX_LEN_DEF + 1)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
